[rtl/mcfc_pkg.sv]
package mcfc_pkg;

	localparam int unsigned BYTE_W   = 8;
	localparam int unsigned STATUS_W = 2;
	localparam int unsigned CHECK_W  = 7;

	localparam logic [BYTE_W-1:0] START_MARK = 8'h3B;
	localparam logic [BYTE_W-1:0] PRINT_LOW  = 8'h20;
	localparam logic [BYTE_W-1:0] PRINT_HIGH = 8'h7F;
	localparam logic [BYTE_W-1:0] DIGIT_LOW  = 8'h30;
	localparam logic [BYTE_W-1:0] DIGIT_HIGH = 8'h39;

	localparam int unsigned CHECK_MOD = 99;
	// most folds of the modulus needed for (sum below 99) plus one byte
	localparam int unsigned SUM_FOLDS = 3;

	typedef enum logic [STATUS_W-1:0] {
		ST_MATCH     = 2'd0,
		ST_MISMATCH  = 2'd1,
		ST_TRUNCATED = 2'd2
	} status_t;

endpackage

[rtl/mcfc_byte_if.sv]
interface mcfc_byte_if
	import mcfc_pkg::*;
();
	logic              valid;
	logic              ready;
	logic [BYTE_W-1:0] rx_byte;

	modport source (output valid, output rx_byte, input ready);
	modport sink   (input valid, input rx_byte, output ready);
endinterface

[rtl/mcfc_result_if.sv]
interface mcfc_result_if
	import mcfc_pkg::*;
();
	logic                valid;
	logic                ready;
	logic [STATUS_W-1:0] frame_status;
	logic [CHECK_W-1:0]  received_check;
	logic [CHECK_W-1:0]  computed_check;

	modport source (output valid, output frame_status, output received_check,
		output computed_check, input ready);
	modport sink   (input valid, input frame_status, input received_check,
		input computed_check, output ready);
endinterface

[rtl/mod99_checksum_frame_checker.sv]
// mod-99 checksum frame checker: takes one received byte per request on rx and
// reports one result per frame on result. a frame is ';', two check characters
// read as a decimal number (a non-digit ends the number, a leading non-digit
// gives 0), then printable payload bytes 0x20..0x7f summed modulo 99. a byte
// below 0x20 or at/above 0x80 ends the frame: status 0 if sum mod 99 plus one
// equals the check value, 1 if not, 2 if the frame ended inside the check
// field. any ';' restarts the frame; bytes outside a frame are dropped. rx
// accepts one byte every cycle unless a finished frame waits on a held result;
// a byte is captured in an input register, and the frame state and the
// registered result are updated from that register. the sustained rate of
// one byte per cycle rests on the combinational add, fold and compare of the
// frame state update; a result waiting on result only holds rx back when a
// second result is ready behind it.
module mod99_checksum_frame_checker
	import mcfc_pkg::*;
(
	input  logic         clk,
	input  logic         arst_n,
	mcfc_byte_if.sink    rx,
	mcfc_result_if.source result
);

	typedef enum logic [1:0] {
		PH_IDLE = 2'd0,
		PH_CHK1 = 2'd1,
		PH_CHK2 = 2'd2,
		PH_BODY = 2'd3
	} phase_t;

	localparam logic [BYTE_W:0] MOD1 = (BYTE_W+1)'(CHECK_MOD);
	localparam logic [BYTE_W:0] MOD2 = (BYTE_W+1)'(CHECK_MOD * 2);
	localparam logic [BYTE_W:0] MOD3 = (BYTE_W+1)'(CHECK_MOD * SUM_FOLDS);

	// input register
	logic              valid_s1;
	logic [BYTE_W-1:0] byte_s1;

	// frame state
	phase_t             phase_q;
	logic [CHECK_W-1:0] check_q;
	logic               stopped_q;
	logic [CHECK_W-1:0] sum_q;

	// result register
	logic                res_valid_q;
	logic [STATUS_W-1:0] res_status_q;
	logic [CHECK_W-1:0]  res_rx_q;
	logic [CHECK_W-1:0]  res_comp_q;

	// next state and result of the byte in the input register
	phase_t              phase_d;
	logic [CHECK_W-1:0]  check_d;
	logic                stopped_d;
	logic [CHECK_W-1:0]  sum_d;
	logic                has_res;
	logic [STATUS_W-1:0] status_d;
	logic [CHECK_W-1:0]  comp_d;

	logic               is_start;
	logic               is_term;
	logic               is_digit;
	logic [BYTE_W:0]    sum_raw;
	logic [BYTE_W:0]    sum_fold;
	logic [CHECK_W-1:0] check_x10;
	logic [CHECK_W-1:0] body_comp;

	logic out_free;
	logic s1_go;

	assign is_start = (byte_s1 == START_MARK);
	assign is_term  = (byte_s1 < PRINT_LOW) || (byte_s1 > PRINT_HIGH);
	assign is_digit = (byte_s1 >= DIGIT_LOW) && (byte_s1 <= DIGIT_HIGH);

	// sum stays below 99, so sum plus a byte needs at most three folds
	assign sum_raw = {{(BYTE_W + 1 - CHECK_W){1'b0}}, sum_q} + {1'b0, byte_s1};
	always_comb begin
		if (sum_raw >= MOD3) begin
			sum_fold = sum_raw - MOD3;
		end else if (sum_raw >= MOD2) begin
			sum_fold = sum_raw - MOD2;
		end else if (sum_raw >= MOD1) begin
			sum_fold = sum_raw - MOD1;
		end else begin
			sum_fold = sum_raw;
		end
	end

	// times ten as shift and add; at most 9 * 10 + 9 so seven bits hold it
	assign check_x10 = {check_q[CHECK_W-2:0], 1'b0} + {check_q[CHECK_W-4:0], 3'b000};
	assign body_comp = sum_q + CHECK_W'(1);

	always_comb begin
		phase_d   = phase_q;
		check_d   = check_q;
		stopped_d = stopped_q;
		sum_d     = sum_q;
		has_res   = 1'b0;
		status_d  = ST_TRUNCATED;
		comp_d    = CHECK_W'(1);
		if (is_start) begin
			// restart from any phase, the last marker wins
			phase_d   = PH_CHK1;
			check_d   = '0;
			stopped_d = 1'b0;
			sum_d     = '0;
		end else begin
			case (phase_q)
				PH_CHK1, PH_CHK2: begin
					if (is_term) begin
						// frame cut short inside the check field
						has_res  = 1'b1;
						status_d = ST_TRUNCATED;
						comp_d   = CHECK_W'(1);
						phase_d  = PH_IDLE;
					end else begin
						if (is_digit && !stopped_q) begin
							check_d = check_x10
								+ {{(CHECK_W - 4){1'b0}}, byte_s1[3:0]};
						end else begin
							stopped_d = 1'b1;
						end
						phase_d = (phase_q == PH_CHK1) ? PH_CHK2 : PH_BODY;
					end
				end
				PH_BODY: begin
					if (is_term) begin
						has_res  = 1'b1;
						comp_d   = body_comp;
						status_d = (body_comp == check_q) ? ST_MATCH : ST_MISMATCH;
						phase_d  = PH_IDLE;
					end else begin
						sum_d = sum_fold[CHECK_W-1:0];
					end
				end
				default: begin
					// waiting for a start marker, byte dropped
				end
			endcase
		end
	end

	// the input register moves on unless its result would overwrite one still waiting
	assign out_free = !res_valid_q || result.ready;
	assign s1_go    = valid_s1 && (!has_res || out_free);
	assign rx.ready = !valid_s1 || s1_go;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1     <= 1'b0;
			phase_q      <= PH_IDLE;
			check_q      <= '0;
			stopped_q    <= 1'b0;
			sum_q        <= '0;
			res_valid_q  <= 1'b0;
			res_status_q <= '0;
			res_rx_q     <= '0;
			res_comp_q   <= '0;
		end else begin
			if (rx.ready) begin
				valid_s1 <= rx.valid;
			end
			if (s1_go) begin
				phase_q   <= phase_d;
				check_q   <= check_d;
				stopped_q <= stopped_d;
				sum_q     <= sum_d;
			end
			if (s1_go && has_res) begin
				res_valid_q  <= 1'b1;
				res_status_q <= status_d;
				res_rx_q     <= check_q;
				res_comp_q   <= comp_d;
			end else if (result.ready) begin
				res_valid_q <= 1'b0;
			end
		end
	end

	// input byte register, no reset
	always_ff @(posedge clk) begin
		if (rx.ready && rx.valid) begin
			byte_s1 <= rx.rx_byte;
		end
	end

	assign result.valid          = res_valid_q;
	assign result.frame_status   = res_status_q;
	assign result.received_check = res_rx_q;
	assign result.computed_check = res_comp_q;

`ifndef SYNTHESIS
	// running sum is always reduced below the modulus
	a_sum_reduced: assert property (@(posedge clk) disable iff (!arst_n)
		sum_q < CHECK_W'(CHECK_MOD))
		else $error("running sum not reduced");

	// a match result carries equal check values
	a_match_equal: assert property (@(posedge clk) disable iff (!arst_n)
		(res_valid_q && res_status_q == ST_MATCH) |-> (res_rx_q == res_comp_q))
		else $error("match reported with differing checks");

	// a truncated frame reports the empty-payload check
	a_trunc_comp: assert property (@(posedge clk) disable iff (!arst_n)
		(res_valid_q && res_status_q == ST_TRUNCATED) |-> (res_comp_q == CHECK_W'(1)))
		else $error("truncated frame with nonempty computed check");

	// a start marker taken from the input register always opens the check field
	a_start_restart: assert property (@(posedge clk) disable iff (!arst_n)
		(s1_go && is_start) |=> (phase_q == PH_CHK1 && sum_q == '0 && check_q == '0))
		else $error("start marker did not restart frame");

	// a waiting result is never overwritten
	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		(res_valid_q && !result.ready) |-> !(s1_go && has_res))
		else $error("result overwritten while stalled");
`endif

endmodule

[tb/testbench.sv]
module testbench;
	import mcfc_pkg::*;

	// longest stretch without any request moving before the run is declared hung;
	// the deliberate receiver hold-off below is far shorter than this
	localparam int QUIET_LIMIT   = 3000;
	// settling after the last expected result before the next test starts
	localparam int SETTLE_CYCLES = 6;
	localparam int HOLD_OFF      = 300;
	localparam int PRINT_CAP     = 30;

	typedef enum logic [1:0] {
		PH_WAIT_MARK,
		PH_CHECK_HI,
		PH_CHECK_LO,
		PH_PAYLOAD
	} parse_phase_t;

	typedef struct packed {
		status_t              status;
		logic [CHECK_W-1:0]   rcv_check;
		logic [CHECK_W-1:0]   comp_check;
	} frame_result_t;

	logic clk = 1'b0;
	logic arst_n;

	mcfc_byte_if   rx_if ();
	mcfc_result_if res_if ();

	mod99_checksum_frame_checker dut (
		.clk    (clk),
		.arst_n (arst_n),
		.rx     (rx_if),
		.result (res_if)
	);

	always #4 clk = ~clk;

	// frame parser state kept alongside the block
	parse_phase_t       parse_phase;
	logic [CHECK_W-1:0] check_acc;
	logic               check_stopped;
	logic [CHECK_W-1:0] payload_sum;

	frame_result_t pending_results[$];

	int error_count;
	int quiet_cycles;
	int send_idle_pct;
	int recv_stall_pct;
	int hold_cycles;
	int bytes_sent;
	int frame_bytes;
	int match_seen;
	int mismatch_seen;
	int truncated_seen;

	task automatic report_error(input string msg);
		error_count++;
		if (error_count <= PRINT_CAP)
			$display("error %0d at %0t: %s", error_count, $time, msg);
	endtask

	// advance the frame parser by one accepted byte and queue any result it gives
	task automatic track_frame_byte(input logic [BYTE_W-1:0] b);
		frame_result_t res;
		logic          is_term;
		logic          is_digit;
		int            next_sum;
		is_term  = (b < PRINT_LOW) || (b > PRINT_HIGH);
		is_digit = (b >= DIGIT_LOW) && (b <= DIGIT_HIGH);
		if (b == START_MARK) begin
			// a start marker restarts the frame wherever it lands
			parse_phase   = PH_CHECK_HI;
			check_acc     = '0;
			check_stopped = 1'b0;
			payload_sum   = '0;
		end else begin
			case (parse_phase)
				PH_CHECK_HI, PH_CHECK_LO: begin
					if (is_term) begin
						// frame cut short inside the check field
						res.status     = ST_TRUNCATED;
						res.rcv_check  = check_acc;
						res.comp_check = 7'd1;
						pending_results.push_back(res);
						parse_phase = PH_WAIT_MARK;
					end else begin
						if (is_digit && !check_stopped)
							check_acc = CHECK_W'(int'(check_acc) * 10 + int'(b - DIGIT_LOW));
						else
							check_stopped = 1'b1;
						parse_phase = (parse_phase == PH_CHECK_HI) ? PH_CHECK_LO : PH_PAYLOAD;
					end
				end
				PH_PAYLOAD: begin
					if (is_term) begin
						res.comp_check = payload_sum + 7'd1;
						res.rcv_check  = check_acc;
						res.status     = (res.comp_check == check_acc) ? ST_MATCH : ST_MISMATCH;
						pending_results.push_back(res);
						parse_phase = PH_WAIT_MARK;
					end else begin
						next_sum    = (int'(payload_sum) + int'(b)) % CHECK_MOD;
						payload_sum = CHECK_W'(next_sum);
					end
				end
				default: ;  // bytes between frames are dropped
			endcase
		end
	endtask

	// sampling at the rising edge: bytes feed the parser, results are checked
	always @(posedge clk) begin
		frame_result_t want;
		if (arst_n) begin
			if (rx_if.valid && rx_if.ready)
				track_frame_byte(rx_if.rx_byte);
			if (res_if.valid && res_if.ready) begin
				if (pending_results.size() == 0) begin
					report_error($sformatf("unexpected result status %0d rcv %0d comp %0d",
						res_if.frame_status, res_if.received_check, res_if.computed_check));
				end else begin
					want = pending_results.pop_front();
					if (res_if.frame_status !== want.status)
						report_error($sformatf("frame_status got %0d expected %0d",
							res_if.frame_status, want.status));
					if (res_if.received_check !== want.rcv_check)
						report_error($sformatf("received_check got %0d expected %0d",
							res_if.received_check, want.rcv_check));
					if (res_if.computed_check !== want.comp_check)
						report_error($sformatf("computed_check got %0d expected %0d",
							res_if.computed_check, want.comp_check));
					case (want.status)
						ST_MATCH:     match_seen++;
						ST_MISMATCH:  mismatch_seen++;
						ST_TRUNCATED: truncated_seen++;
						default: ;
					endcase
				end
			end
			// watchdog: any request moving on either side resets the count
			if ((rx_if.valid && rx_if.ready) || (res_if.valid && res_if.ready))
				quiet_cycles = 0;
			else
				quiet_cycles++;
			if (quiet_cycles >= QUIET_LIMIT) begin
				$display("timeout: no request moved for %0d cycles", QUIET_LIMIT);
				$display("** mod99_checksum_frame_checker: FAILED **");
				$finish;
			end
		end
	end

	// result side: random stalls, plus a counted hold-off when a test asks for it
	initial begin
		res_if.ready = 1'b0;
		forever begin
			@(negedge clk);
			if (hold_cycles > 0) begin
				res_if.ready <= 1'b0;
				hold_cycles--;
			end else begin
				res_if.ready <= ($urandom_range(99) >= recv_stall_pct);
			end
		end
	end

	// drive a byte sequence, one request per byte, with random sender gaps;
	// starts and ends on a falling edge
	task automatic send_seq(input logic [BYTE_W-1:0] seq[$]);
		foreach (seq[i]) begin
			while ($urandom_range(99) < send_idle_pct) begin
				rx_if.valid <= 1'b0;
				@(negedge clk);
			end
			rx_if.valid   <= 1'b1;
			rx_if.rx_byte <= seq[i];
			do @(posedge clk); while (!rx_if.ready);
			@(negedge clk);
			bytes_sent++;
		end
	endtask

	// sender goes quiet until every queued result is back, then lets the block settle
	task automatic wait_drained();
		rx_if.valid <= 1'b0;
		while (pending_results.size() != 0)
			@(negedge clk);
		repeat (SETTLE_CYCLES) @(negedge clk);
	endtask

	function automatic logic [BYTE_W-1:0] printable_byte();
		logic [BYTE_W-1:0] b;
		do b = BYTE_W'($urandom_range(PRINT_LOW, PRINT_HIGH)); while (b == START_MARK);
		return b;
	endfunction

	function automatic logic [BYTE_W-1:0] check_char();
		if ($urandom_range(1))
			return DIGIT_LOW + BYTE_W'($urandom_range(9));
		return printable_byte();
	endfunction

	// one random frame, mostly well formed, sometimes noise or broken
	task automatic send_random_frame();
		logic [BYTE_W-1:0] frame[$];
		logic [BYTE_W-1:0] body[$];
		logic [BYTE_W-1:0] b;
		int                kind;
		int                len;
		int                sum;
		int                chk;
		kind = $urandom_range(99);
		if (kind < 10) begin
			// noise between frames, any byte value
			repeat ($urandom_range(1, 4)) frame.push_back(BYTE_W'($urandom_range(255)));
		end else begin
			if (kind >= 30 && kind < 40) begin
				// abandoned frame that a later marker restarts
				frame.push_back(START_MARK);
				repeat ($urandom_range(0, 5)) frame.push_back(printable_byte());
			end
			frame.push_back(START_MARK);
			if (kind < 20) begin
				// terminator lands inside the check field
				if ($urandom_range(1)) frame.push_back(check_char());
			end else begin
				len = (kind >= 40 && kind < 45) ? $urandom_range(20, 40) : $urandom_range(0, 10);
				sum = 0;
				repeat (len) begin
					b = printable_byte();
					body.push_back(b);
					sum = (sum + int'(b)) % CHECK_MOD;
				end
				if (kind < 30) begin
					frame.push_back(check_char());
					frame.push_back(check_char());
				end else begin
					// mostly the right check value, sometimes an arbitrary one
					chk = ($urandom_range(4) == 0) ? $urandom_range(0, 99) : sum + 1;
					frame.push_back(DIGIT_LOW + BYTE_W'(chk / 10));
					frame.push_back(DIGIT_LOW + BYTE_W'(chk % 10));
				end
				frame = {frame, body};
			end
			// terminator from either band
			frame.push_back($urandom_range(1) ? BYTE_W'($urandom_range(0, PRINT_LOW - 1))
				: BYTE_W'($urandom_range(PRINT_HIGH + 1, 255)));
			frame_bytes += frame.size();
		end
		send_seq(frame);
	endtask

	// hand-picked frames: field extremes, every status, restarts and truncation
	task automatic test_directed();
		logic [BYTE_W-1:0] seq[$];
		send_idle_pct  = 0;
		recv_stall_pct = 0;
		seq = {
			// ";01" empty payload, match at the smallest computed value
			START_MARK, 8'h30, 8'h31, 8'h0A,
			// ";99b" sum 98, match at the largest check value, 0xff ends it
			START_MARK, 8'h39, 8'h39, 8'h62, 8'hFF,
			// ";00" payload at both printable edges, 0x80 ends it, mismatch
			START_MARK, 8'h30, 8'h30, PRINT_LOW, PRINT_HIGH, 8'h80,
			// marker then 0x00: truncated with nothing parsed
			START_MARK, 8'h00,
			// ";4" restarted by ";7", then truncated by 0x1f
			START_MARK, 8'h34, START_MARK, 8'h37, 8'h1F,
			// ";x5" leading non-digit gives 0, digit after it is ignored
			START_MARK, 8'h78, 8'h35, 8'h7E, 8'h0D
		};
		send_seq(seq);
		frame_bytes += seq.size();
		wait_drained();
	endtask

	task automatic test_random_frames(input int idle_pct, input int stall_pct, input int target);
		int stop_at;
		send_idle_pct  = idle_pct;
		recv_stall_pct = stall_pct;
		stop_at        = frame_bytes + target;
		while (frame_bytes < stop_at)
			send_random_frame();
		wait_drained();
	endtask

	// receiver holds off for a long stretch while short frames keep coming, so
	// results back up and the block stops taking bytes
	task automatic test_backpressure();
		logic [BYTE_W-1:0] seq[$];
		send_idle_pct  = 0;
		recv_stall_pct = 0;
		hold_cycles    = HOLD_OFF;
		repeat (12) seq = {seq, START_MARK, 8'h30, 8'h31, 8'h0A};
		send_seq(seq);
		frame_bytes += seq.size();
		wait_drained();
		repeat (8) send_random_frame();
		wait_drained();
	endtask

	initial begin
		arst_n         = 1'b0;
		rx_if.valid    = 1'b0;
		rx_if.rx_byte  = '0;
		parse_phase    = PH_WAIT_MARK;
		check_acc      = '0;
		check_stopped  = 1'b0;
		payload_sum    = '0;
		error_count    = 0;
		quiet_cycles   = 0;
		send_idle_pct  = 0;
		recv_stall_pct = 0;
		hold_cycles    = 0;
		bytes_sent     = 0;
		frame_bytes    = 0;
		match_seen     = 0;
		mismatch_seen  = 0;
		truncated_seen = 0;
		repeat (3) @(negedge clk);
		arst_n = 1'b1;

		test_directed();
		test_random_frames(0, 0, 75);
		test_random_frames(88, 0, 75);
		test_random_frames(0, 88, 75);
		test_random_frames(26, 26, 75);
		test_backpressure();

		$display("sent %0d bytes over directed, random-gap, stalled and held-off phases",
			bytes_sent);
		$display("frames checked: %0d match, %0d mismatch, %0d truncated in check field",
			match_seen, mismatch_seen, truncated_seen);
		if (error_count == 0) begin
			$display("** mod99_checksum_frame_checker: PASSED **");
		end else begin
			$display("** mod99_checksum_frame_checker: FAILED **");
		end
		$finish;
	end

endmodule

[sim.f]
rtl/mcfc_pkg.sv
rtl/mcfc_byte_if.sv
rtl/mcfc_result_if.sv
rtl/mod99_checksum_frame_checker.sv
tb/testbench.sv
